[rtl/core/three_motor_slew_ramp_timeout_core_defines.svh]
// assertion macros shared by the checker of the three-motor ramp core
// no dependencies; included by the checker file only
`ifndef THREE_MOTOR_SLEW_RAMP_TIMEOUT_CORE_DEFINES_SVH
`define THREE_MOTOR_SLEW_RAMP_TIMEOUT_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TMSR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define TMSR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tmsr_pkg.sv]
// types, constants and helper functions of the three-motor ramp core
// no dependencies; imported by every module of the block
package tmsr_pkg;

  localparam int NUM_MOTORS    = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SPEED_W       = 8;
  localparam int MAG_W         = 8;
  localparam int LIM_W         = 7;
  localparam int SLEW_W        = 7;
  localparam int STEPS_W       = 16;
  localparam int WD_W          = 16;
  localparam int ACTION_W      = 2;
  localparam int SEL_W         = 2;
  localparam int BATT_W        = 8;
  localparam int VOLT_W        = 8;
  localparam int S_TDATA_W     = 40;
  localparam int M_TDATA_W     = 40;
  localparam int APB_AW        = 4;
  localparam int APB_DW        = 32;

  localparam logic [LIM_W-1:0]  MAX_SPEED_RST = 7'd100;
  localparam logic [SLEW_W-1:0] SLEW_RST      = 7'd1;
  localparam logic [WD_W-1:0]   TIMEOUT_RST   = 16'd100;

  // voltage = (raw + 148) * 7 / 27, the divide done by reciprocal multiply
  localparam int VOLT_OFS   = 148;
  localparam int VOLT_MUL   = 7;
  localparam int VOLT_RECIP = 2428;
  localparam int VOLT_SHIFT = 16;
  localparam int VOLT_FULL  = 255;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_SET    = 2'd1,
    ACT_DIRECT = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_MAX_SPEED = 2'd0,
    REG_SLEW_RATE = 2'd1,
    REG_TIMEOUT   = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SPAN,
    ST_DIV,
    ST_APPLY,
    ST_STEP,
    ST_DONE
  } state_e;

  // sequencer commands shared by all lanes
  typedef struct packed {
    logic load_req;
    logic cmp;
    logic div_init;
    logic div_run;
    logic apply;
    logic step_add;
    logic step_snap;
  } lane_ctrl_t;

  // what the merge stage makes of the lanes
  typedef struct packed {
    logic               same_all;
    logic [STEPS_W-1:0] steps;
  } span_t;

  function automatic logic signed [SPEED_W-1:0] clamp_speed(
    input logic signed [SPEED_W-1:0] s,
    input logic [LIM_W-1:0]          lim
  );
    logic signed [SPEED_W:0] sx;
    logic signed [SPEED_W:0] lx;
    logic signed [SPEED_W:0] nx;
    sx = $signed({s[SPEED_W-1], s});
    lx = $signed({2'b00, lim});
    nx = -lx;
    if (sx < nx) begin
      return nx[SPEED_W-1:0];
    end else if (sx > lx) begin
      return lx[SPEED_W-1:0];
    end else begin
      return s;
    end
  endfunction

  function automatic logic [VOLT_W-1:0] volt_of(input logic [BATT_W-1:0] raw);
    logic [11:0] x;
    logic [23:0] p;
    x = (12'(raw) + 12'(VOLT_OFS)) * 12'(VOLT_MUL);
    p = 24'(x) * 24'(VOLT_RECIP);
    if (raw == '0) begin
      return VOLT_W'(VOLT_FULL);
    end else begin
      return p[VOLT_SHIFT +: VOLT_W];
    end
  endfunction

endpackage

[rtl/core/tmsr_lane.sv]
// one motor lane: clamp, change magnitude, serial restoring divider and ramp accumulator
// depends on tmsr_pkg
module tmsr_lane
  import tmsr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lane_ctrl_t                ctrl_i,
  input  logic                      direct_i,
  input  logic signed [SPEED_W-1:0] req_i,
  input  logic [LIM_W-1:0]          lim_i,
  input  logic [STEPS_W-1:0]        steps_i,
  output logic signed [SPEED_W-1:0] speed_o,
  output logic [MAG_W-1:0]          mag_o,
  output logic                      same_o
);

  localparam int ACC_W = SPEED_W + FRAC_BITS;
  localparam int INC_W = FRAC_BITS + 2;
  localparam int DIV_W = MAG_W + FRAC_BITS;

  logic signed [SPEED_W-1:0] req_q, req_d;
  logic signed [SPEED_W-1:0] cur_q, cur_d;
  logic signed [SPEED_W-1:0] tgt_q, tgt_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [INC_W-1:0]   inc_q, inc_d;
  logic [MAG_W-1:0]          mag_q, mag_d;
  logic                      neg_q, neg_d;
  logic                      same_q, same_d;
  logic [STEPS_W-1:0]        rem_q, rem_d;
  logic [DIV_W-1:0]          quo_q, quo_d;

  logic signed [SPEED_W:0]   diff_c;
  logic signed [SPEED_W:0]   abs_c;
  logic [STEPS_W:0]          trial_c;
  logic [STEPS_W:0]          sub_c;
  logic                      ge_c;
  logic signed [INC_W-1:0]   quot_c;
  logic signed [ACC_W-1:0]   acc_sum_c;
  logic signed [SPEED_W-1:0] whole_c;

  always_comb begin
    diff_c    = $signed({req_q[SPEED_W-1], req_q}) - $signed({cur_q[SPEED_W-1], cur_q});
    abs_c     = diff_c[SPEED_W] ? -diff_c : diff_c;
    trial_c   = {rem_q, quo_q[DIV_W-1]};
    sub_c     = trial_c - {1'b0, steps_i};
    ge_c      = (trial_c >= {1'b0, steps_i});
    quot_c    = $signed({1'b0, quo_q[FRAC_BITS:0]});
    acc_sum_c = acc_q + $signed({{(ACC_W-INC_W){inc_q[INC_W-1]}}, inc_q});
    // arithmetic shift floors, so negative values with a fraction move up by one
    whole_c   = acc_sum_c[ACC_W-1:FRAC_BITS];
    if (acc_sum_c[ACC_W-1] && (acc_sum_c[FRAC_BITS-1:0] != '0)) begin
      whole_c = whole_c + SPEED_W'(1);
    end

    req_d  = req_q;
    cur_d  = cur_q;
    tgt_d  = tgt_q;
    acc_d  = acc_q;
    inc_d  = inc_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    same_d = same_q;
    rem_d  = rem_q;
    quo_d  = quo_q;

    if (ctrl_i.load_req) begin
      req_d = clamp_speed(req_i, lim_i);
    end
    if (direct_i) begin
      cur_d = clamp_speed(req_i, lim_i);
    end
    if (ctrl_i.cmp) begin
      mag_d  = abs_c[MAG_W-1:0];
      neg_d  = diff_c[SPEED_W];
      same_d = (req_q == tgt_q);
    end
    if (ctrl_i.div_init) begin
      rem_d = '0;
      quo_d = {mag_q, {FRAC_BITS{1'b0}}};
    end
    if (ctrl_i.div_run) begin
      rem_d = ge_c ? sub_c[STEPS_W-1:0] : trial_c[STEPS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge_c};
    end
    if (ctrl_i.apply) begin
      tgt_d = req_q;
      acc_d = $signed({cur_q, {FRAC_BITS{1'b0}}});
      if (steps_i == '0) begin
        inc_d = '0;
      end else begin
        inc_d = neg_q ? -quot_c : quot_c;
      end
    end
    if (ctrl_i.step_add) begin
      acc_d = acc_sum_c;
      cur_d = whole_c;
    end
    if (ctrl_i.step_snap) begin
      cur_d = tgt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      tgt_q <= '0;
      acc_q <= '0;
      inc_q <= '0;
    end else begin
      cur_q <= cur_d;
      tgt_q <= tgt_d;
      acc_q <= acc_d;
      inc_q <= inc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    same_q <= same_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign speed_o = cur_q;
  assign mag_o   = mag_q;
  assign same_o  = same_q;

endmodule

[rtl/core/tmsr_merge.sv]
// merge stage: largest change over the lanes, ramp length and the no-change flag
// depends on tmsr_pkg
module tmsr_merge
  import tmsr_pkg::*;
(
  input  logic [MAG_W-1:0]  mag_i [NUM_MOTORS],
  input  logic              same_i [NUM_MOTORS],
  input  logic [SLEW_W-1:0] slew_i,
  output span_t             span_o
);

  logic [MAG_W-1:0]        big_c;
  logic                    same_c;
  logic [MAG_W+SLEW_W-1:0] prod_c;

  always_comb begin
    big_c  = '0;
    same_c = 1'b1;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      if (mag_i[i] > big_c) begin
        big_c = mag_i[i];
      end
      same_c = same_c & same_i[i];
    end
    prod_c          = (MAG_W+SLEW_W)'(big_c) * (MAG_W+SLEW_W)'(slew_i);
    span_o.same_all = same_c;
    span_o.steps    = STEPS_W'(prod_c);
  end

endmodule

[rtl/core/three_motor_slew_ramp_timeout_core.sv]
// top level of the three-motor slew-rate ramp with watchdog
// depends on tmsr_pkg, tmsr_lane and tmsr_merge
//
// Use: items arrive on the s_axis stream (kind in tuser: tick, set targets,
// direct set), one result per item leaves on the m_axis stream with the three
// motor speeds, the battery voltage (ticks only) and the watchdog flag. Limits,
// slew rate and watchdog timeout sit in an APB register bank (0x0, 0x4, 0x8),
// to be written only while the block is idle; the block does not enforce this.
// The ramp setup is paced by the three restoring dividers, one per motor
// lane, each retiring one quotient bit a cycle over 8 + FRAC_BITS bits. One
// item is in work at a time; the next is taken once the result sits in the
// output register. A direct set or unused kind goes straight to the result,
// a tick steps the ramp, set targets are compared and, when a target moved,
// divided, and a tick that fires the watchdog retargets and then steps.
// Reset: speeds, targets and ramp state clear, registers return to 100 / 1 /
// 100. A stalled receiver holds the result; the block finishes the next item
// and then waits with s_axis_tready low until the output register frees.
module three_motor_slew_ramp_timeout_core
  import tmsr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // target_a [7:0], target_b [15:8], target_c [23:16], motor_select [25:24],
  // battery_raw [33:26], zero fill above
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // action [1:0]
  input  logic [ACTION_W-1:0]  s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // speed_a [7:0], speed_b [15:8], speed_c [23:16], voltage [31:24],
  // timed_out [32], zero fill above
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int DIV_W  = MAG_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(DIV_W);

  state_e              state_q, state_d;
  action_e             action_q, action_d;
  logic                fired_q, fired_d;
  logic [BATT_W-1:0]   batt_q, batt_d;
  logic [WD_W-1:0]     wd_q, wd_d;
  logic [STEPS_W-1:0]  steps_q, steps_d;
  logic [STEPS_W-1:0]  count_q, count_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [LIM_W-1:0]    max_speed_q, max_speed_d;
  logic [SLEW_W-1:0]   slew_q, slew_d;
  logic [WD_W-1:0]     timeout_q, timeout_d;
  logic                m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  lane_ctrl_t                ctrl_c;
  logic [NUM_MOTORS-1:0]     direct_c;
  logic signed [SPEED_W-1:0] in_tgt [NUM_MOTORS];
  logic signed [SPEED_W-1:0] lane_req [NUM_MOTORS];
  logic signed [SPEED_W-1:0] lane_speed [NUM_MOTORS];
  logic [MAG_W-1:0]          lane_mag [NUM_MOTORS];
  logic                      lane_same [NUM_MOTORS];
  span_t                     span_c;

  action_e           in_action;
  logic [SEL_W-1:0]  in_sel;
  logic [BATT_W-1:0] in_batt;
  logic              in_beat;
  logic [WD_W-1:0]   wd_inc;
  logic              wd_fire;
  logic              cfg_wr;
  reg_e              cfg_reg;

  assign in_action = action_e'(s_axis_tuser);
  assign in_sel    = s_axis_tdata[3*SPEED_W +: SEL_W];
  assign in_batt   = s_axis_tdata[3*SPEED_W+SEL_W +: BATT_W];
  assign in_beat   = s_axis_tvalid & s_axis_tready;
  assign wd_inc    = wd_q + WD_W'(1);
  assign wd_fire   = (wd_inc == timeout_q);

  genvar g;
  generate
    for (g = 0; g < NUM_MOTORS; g++) begin : g_lane
      assign in_tgt[g] = s_axis_tdata[g*SPEED_W +: SPEED_W];

      tmsr_lane #(
        .FRAC_BITS(FRAC_BITS)
      ) u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl_c),
        .direct_i(direct_c[g]),
        .req_i   (lane_req[g]),
        .lim_i   (max_speed_q),
        .steps_i (steps_q),
        .speed_o (lane_speed[g]),
        .mag_o   (lane_mag[g]),
        .same_o  (lane_same[g])
      );
    end
  endgenerate

  tmsr_merge u_merge (
    .mag_i (lane_mag),
    .same_i(lane_same),
    .slew_i(slew_q),
    .span_o(span_c)
  );

  // register bank
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_reg = reg_e'(paddr[3:2]);

  always_comb begin
    max_speed_d = max_speed_q;
    slew_d      = slew_q;
    timeout_d   = timeout_q;
    prdata      = '0;
    case (cfg_reg)
      REG_MAX_SPEED: begin
        prdata = APB_DW'(max_speed_q);
        if (cfg_wr) max_speed_d = pwdata[LIM_W-1:0];
      end
      REG_SLEW_RATE: begin
        prdata = APB_DW'(slew_q);
        if (cfg_wr) slew_d = pwdata[SLEW_W-1:0];
      end
      REG_TIMEOUT: begin
        prdata = APB_DW'(timeout_q);
        if (cfg_wr) timeout_d = pwdata[WD_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    action_d  = action_q;
    fired_d   = fired_q;
    batt_d    = batt_q;
    wd_d      = wd_q;
    steps_d   = steps_q;
    count_d   = count_q;
    dcnt_d    = dcnt_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    ctrl_c    = '0;
    direct_c  = '0;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      lane_req[i] = '0;
    end

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          action_d = in_action;
          batt_d   = in_batt;
          fired_d  = 1'b0;
          case (in_action)
            ACT_TICK: begin
              wd_d = wd_inc;
              if (wd_fire) begin
                // watchdog retargets every motor to zero
                wd_d            = '0;
                fired_d         = 1'b1;
                ctrl_c.load_req = 1'b1;
                state_d         = ST_CMP;
              end else begin
                state_d = ST_STEP;
              end
            end
            ACT_SET: begin
              wd_d            = '0;
              ctrl_c.load_req = 1'b1;
              for (int i = 0; i < NUM_MOTORS; i++) begin
                lane_req[i] = in_tgt[i];
              end
              state_d = ST_CMP;
            end
            ACT_DIRECT: begin
              for (int i = 0; i < NUM_MOTORS; i++) begin
                lane_req[i] = in_tgt[0];
                direct_c[i] = (in_sel == SEL_W'(i));
              end
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_CMP: begin
        ctrl_c.cmp = 1'b1;
        state_d    = ST_SPAN;
      end
      ST_SPAN: begin
        if (span_c.same_all) begin
          state_d = (action_q == ACT_TICK) ? ST_STEP : ST_DONE;
        end else begin
          steps_d         = span_c.steps;
          dcnt_d          = '0;
          ctrl_c.div_init = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        ctrl_c.div_run = 1'b1;
        dcnt_d         = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(DIV_W - 1)) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        ctrl_c.apply = 1'b1;
        count_d      = '0;
        state_d      = (action_q == ACT_TICK) ? ST_STEP : ST_DONE;
      end
      ST_STEP: begin
        // count stops one past the last step, so an idle ramp does nothing
        if (count_q < steps_q) begin
          ctrl_c.step_add = 1'b1;
          count_d         = count_q + STEPS_W'(1);
        end else if (count_q == steps_q) begin
          ctrl_c.step_snap = 1'b1;
          count_d          = count_q + STEPS_W'(1);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          for (int i = 0; i < NUM_MOTORS; i++) begin
            m_data_d[i*SPEED_W +: SPEED_W] = lane_speed[i];
          end
          if (action_q == ACT_TICK) begin
            m_data_d[3*SPEED_W +: VOLT_W] = volt_of(batt_q);
          end
          m_data_d[3*SPEED_W+VOLT_W] = fired_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      action_q    <= ACT_NONE;
      fired_q     <= 1'b0;
      wd_q        <= '0;
      steps_q     <= '0;
      count_q     <= STEPS_W'(1);
      dcnt_q      <= '0;
      max_speed_q <= MAX_SPEED_RST;
      slew_q      <= SLEW_RST;
      timeout_q   <= TIMEOUT_RST;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      action_q    <= action_d;
      fired_q     <= fired_d;
      wd_q        <= wd_d;
      steps_q     <= steps_d;
      count_q     <= count_d;
      dcnt_q      <= dcnt_d;
      max_speed_q <= max_speed_d;
      slew_q      <= slew_d;
      timeout_q   <= timeout_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    batt_q   <= batt_d;
    m_data_q <= m_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[rtl/core/tmsr_checker.sv]
// port-level checks for the three-motor ramp core, bound to the top level
// depends on tmsr_pkg and three_motor_slew_ramp_timeout_core_defines.svh
`include "three_motor_slew_ramp_timeout_core_defines.svh"

module tmsr_checker
  import tmsr_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // a result beat waiting on the receiver keeps its payload
  `TMSR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // speeds are clamped, so the most negative byte never shows
  `TMSR_ASSERT_IMP(a_speed_range, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[7:0] != 8'h80) && (m_axis_tdata[15:8] != 8'h80) && (m_axis_tdata[23:16] != 8'h80), "speed outside clamp range")

  // the watchdog only fires on a tick, which always reports a nonzero voltage
  `TMSR_ASSERT_IMP(a_fire_on_tick, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[31:24] != 8'h00, "watchdog flag without tick voltage")

  // one item in work at a time
  `TMSR_ASSERT_NXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while item in work")

endmodule

bind three_motor_slew_ramp_timeout_core tmsr_checker u_tmsr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

[test/three_motor_slew_ramp_timeout_core_tb.sv]
// self-checking bench for the three-motor slew ramp core with watchdog
// needs tmsr_pkg and the core; drives the item stream and the apb bank, scores every result
`timescale 1ns / 100ps

module three_motor_slew_ramp_timeout_core_tb;
  import tmsr_pkg::*;

  localparam int FRAC        = 16;
  localparam int MAX_GAP     = 13;
  localparam int SETTLE      = 40;
  localparam int STALL_LIMIT = 3000;
  localparam int PRINT_CAP   = 200;

  typedef struct packed {
    action_e    act;
    logic [7:0] tgt_a;
    logic [7:0] tgt_b;
    logic [7:0] tgt_c;
    logic [1:0] sel;
    logic [7:0] batt;
  } ramp_item_t;

  typedef struct packed {
    logic [7:0] spd_a;
    logic [7:0] spd_b;
    logic [7:0] spd_c;
    logic [7:0] volt;
    logic       fired;
  } speed_report_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [ACTION_W-1:0]  s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [APB_AW-1:0]    paddr         = '0;
  logic [APB_DW-1:0]    pwdata        = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  three_motor_slew_ramp_timeout_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // ramp state and register copies kept by the bench
  logic signed [7:0]  mot_speed[3];
  logic signed [7:0]  mot_target[3];
  logic signed [23:0] mot_acc[3];
  logic signed [23:0] mot_inc[3];
  logic [15:0]        ramp_len;
  logic [15:0]        ramp_pos;
  logic [15:0]        wd_ticks;
  logic [6:0]         lim_cfg;
  logic [6:0]         slew_cfg;
  logic [15:0]        timeout_cfg;

  ramp_item_t    pending_items[$];
  speed_report_t expected_speeds[$];

  int  n_queued   = 0;
  int  n_accepted = 0;
  int  n_checked  = 0;
  int  n_errors   = 0;
  int  n_ticks    = 0;
  int  n_sets     = 0;
  int  n_directs  = 0;
  int  n_fires    = 0;
  int  n_settings = 1;
  int  stall_cycles = 0;
  bit  idle_on    = 1'b1;
  int  last_a     = 0;
  int  last_b     = 0;
  int  last_c     = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= PRINT_CAP) begin
      $display("[%0t] result %0d: %s got %0d expected %0d", $time, n_checked, what, got, want);
    end
  endtask

  function automatic void clear_ramp_state();
    for (int i = 0; i < 3; i++) begin
      mot_speed[i]  = '0;
      mot_target[i] = '0;
      mot_acc[i]    = '0;
      mot_inc[i]    = '0;
    end
    ramp_len    = '0;
    ramp_pos    = 16'd1;
    wd_ticks    = '0;
    lim_cfg     = 7'd100;
    slew_cfg    = 7'd1;
    timeout_cfg = 16'd100;
  endfunction

  function automatic int clamp_cmd(input int s);
    int lim;
    lim = int'(lim_cfg);
    if (s < -lim) return -lim;
    if (s > lim) return lim;
    return s;
  endfunction

  // new targets: clears the watchdog, starts a ramp only if the targets moved
  function automatic void retarget(input int ra, input int rb, input int rc);
    int     want[3];
    int     big;
    int     d;
    bit     same;
    longint diff;
    want[0]  = clamp_cmd(ra);
    want[1]  = clamp_cmd(rb);
    want[2]  = clamp_cmd(rc);
    wd_ticks = '0;
    same     = 1'b1;
    big      = 0;
    for (int i = 0; i < 3; i++) begin
      if (want[i] != int'(mot_target[i])) same = 1'b0;
    end
    if (same) return;
    for (int i = 0; i < 3; i++) begin
      d = want[i] - int'(mot_speed[i]);
      if (d < 0) d = -d;
      if (d > big) big = d;
    end
    ramp_len = 16'(big * int'(slew_cfg));
    for (int i = 0; i < 3; i++) begin
      diff          = longint'(want[i] - int'(mot_speed[i]));
      mot_target[i] = 8'(want[i]);
      mot_inc[i]    = (ramp_len == 16'd0) ? 24'sd0 :
                      24'((diff <<< FRAC) / longint'(ramp_len));
      mot_acc[i]    = 24'(longint'(mot_speed[i]) <<< FRAC);
    end
    ramp_pos = '0;
  endfunction

  function automatic speed_report_t ramp_predict(input ramp_item_t it);
    speed_report_t r;
    int            b;
    r = '0;
    case (it.act)
      ACT_TICK: begin
        n_ticks++;
        wd_ticks = wd_ticks + 16'd1;
        if (wd_ticks == timeout_cfg) begin
          retarget(0, 0, 0);
          r.fired = 1'b1;
          n_fires++;
        end
        if (ramp_pos < ramp_len) begin
          for (int i = 0; i < 3; i++) begin
            mot_acc[i]   = mot_acc[i] + mot_inc[i];
            // truncate toward zero
            mot_speed[i] = 8'(longint'(mot_acc[i]) / (longint'(1) <<< FRAC));
          end
          ramp_pos = ramp_pos + 16'd1;
        end else if (ramp_pos == ramp_len) begin
          for (int i = 0; i < 3; i++) mot_speed[i] = mot_target[i];
          ramp_pos = ramp_pos + 16'd1;
        end
        b      = int'(it.batt);
        r.volt = (b == 0) ? 8'd255 : 8'(((b + 148) * 7) / 27);
      end
      ACT_SET: begin
        n_sets++;
        retarget($signed(it.tgt_a), $signed(it.tgt_b), $signed(it.tgt_c));
      end
      ACT_DIRECT: begin
        n_directs++;
        if (it.sel < 2'd3) mot_speed[it.sel] = 8'(clamp_cmd($signed(it.tgt_a)));
      end
      default: begin
      end
    endcase
    r.spd_a = mot_speed[0];
    r.spd_b = mot_speed[1];
    r.spd_c = mot_speed[2];
    return r;
  endfunction

  function automatic ramp_item_t make_item(input action_e a, input int ta, input int tb,
                                           input int tc, input int sel, input int batt);
    ramp_item_t it;
    it.act   = a;
    it.tgt_a = 8'(ta);
    it.tgt_b = 8'(tb);
    it.tgt_c = 8'(tc);
    it.sel   = 2'(sel);
    it.batt  = 8'(batt);
    return it;
  endfunction

  // mostly ticks so ramps run out; targets either full range, small moves or a repeat
  function automatic ramp_item_t random_item();
    int      pick;
    int      ta;
    int      tb;
    int      tc;
    int      batt;
    action_e a;
    pick = $urandom_range(0, 99);
    ta   = $urandom_range(0, 255);
    tb   = $urandom_range(0, 255);
    tc   = $urandom_range(0, 255);
    batt = $urandom_range(0, 255);
    if (pick < 62) begin
      a = ACT_TICK;
      if ($urandom_range(0, 15) == 0) batt = 0;
    end else if (pick < 84) begin
      a = ACT_SET;
      case ($urandom_range(0, 3))
        1: begin
          ta = $urandom_range(0, 10) - 5;
          tb = $urandom_range(0, 10) - 5;
          tc = $urandom_range(0, 10) - 5;
        end
        2: begin
          ta = last_a;
          tb = last_b;
          tc = last_c;
        end
        default: begin
        end
      endcase
      last_a = ta;
      last_b = tb;
      last_c = tc;
    end else if (pick < 96) begin
      a = ACT_DIRECT;
    end else begin
      a = ACT_NONE;
    end
    return make_item(a, ta, tb, tc, $urandom_range(0, 3), batt);
  endfunction

  task automatic queue_item(input ramp_item_t it);
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (!(n_accepted == n_queued && n_checked == n_accepted)) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // apb write, then read back the same register
  task automatic program_reg(input reg_e r, input logic [APB_DW-1:0] v);
    logic [APB_DW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_MAX_SPEED: lim_cfg     = v[6:0];
      REG_SLEW_RATE: slew_cfg    = v[6:0];
      REG_TIMEOUT:   timeout_cfg = v[15:0];
      default: begin
      end
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    paddr   <= APB_AW'({r, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got != v) flag_mismatch("register readback", int'(got), int'(v));
  endtask

  task automatic run_phase(input int mx, input int sl, input int to, input bit gaps,
                           input int count);
    wait_drained();
    program_reg(REG_MAX_SPEED, APB_DW'(mx));
    program_reg(REG_SLEW_RATE, APB_DW'(sl));
    program_reg(REG_TIMEOUT, APB_DW'(to));
    n_settings++;
    idle_on = gaps;
    repeat (count) queue_item(random_item());
  endtask

  // item driver
  ramp_item_t beat_item;
  int         gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_speeds.push_back(ramp_predict(beat_item));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          beat_item = pending_items.pop_front();
          s_axis_tdata  <= {6'd0, beat_item.batt, beat_item.sel, beat_item.tgt_c,
                            beat_item.tgt_b, beat_item.tgt_a};
          s_axis_tuser  <= beat_item.act;
          s_axis_tvalid <= 1'b1;
          gap_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        end
      end
    end
  end

  // result monitor and scoreboard
  int            hold_left;
  speed_report_t want_r;
  speed_report_t got_r;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.spd_a = m_axis_tdata[7:0];
        got_r.spd_b = m_axis_tdata[15:8];
        got_r.spd_c = m_axis_tdata[23:16];
        got_r.volt  = m_axis_tdata[31:24];
        got_r.fired = m_axis_tdata[32];
        if (expected_speeds.size() == 0) begin
          flag_mismatch("unexpected beat speed_a", $signed(got_r.spd_a), 0);
        end else begin
          want_r = expected_speeds.pop_front();
          if (got_r.spd_a != want_r.spd_a)
            flag_mismatch("speed_a", $signed(got_r.spd_a), $signed(want_r.spd_a));
          if (got_r.spd_b != want_r.spd_b)
            flag_mismatch("speed_b", $signed(got_r.spd_b), $signed(want_r.spd_b));
          if (got_r.spd_c != want_r.spd_c)
            flag_mismatch("speed_c", $signed(got_r.spd_c), $signed(want_r.spd_c));
          if (got_r.volt != want_r.volt)
            flag_mismatch("voltage", int'(got_r.volt), int'(want_r.volt));
          if (got_r.fired != want_r.fired)
            flag_mismatch("timed_out", int'(got_r.fired), int'(want_r.fired));
          n_checked++;
        end
        hold_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // hang detector: no beat and no register access for too long
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results outstanding",
               STALL_LIMIT, n_accepted - n_checked);
      $display("three_motor_slew_ramp_timeout_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    clear_ramp_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset limits, battery extremes, clamping, direct sets, zero-step snap
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 0));
    queue_item(make_item(ACT_TICK, 255, 255, 255, 3, 255));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 1));
    queue_item(make_item(ACT_SET, 127, -128, 0, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 128));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 77));
    queue_item(make_item(ACT_SET, 127, -128, 0, 0, 0));
    queue_item(make_item(ACT_DIRECT, -128, 0, 0, 0, 0));
    queue_item(make_item(ACT_DIRECT, 127, 0, 0, 1, 0));
    queue_item(make_item(ACT_DIRECT, 8'h55, 0, 0, 2, 0));
    queue_item(make_item(ACT_DIRECT, 100, 0, 0, 3, 0));
    queue_item(make_item(ACT_NONE, 8'hAA, 8'h55, 8'hF0, 1, 8'h3C));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 200));
    queue_item(make_item(ACT_SET, 0, 0, 0, 0, 0));
    queue_item(make_item(ACT_DIRECT, 7, 0, 0, 0, 0));
    queue_item(make_item(ACT_DIRECT, -7, 0, 0, 1, 0));
    queue_item(make_item(ACT_DIRECT, 1, 0, 0, 2, 0));
    // targets equal to the present speeds: zero steps, next tick snaps
    queue_item(make_item(ACT_SET, 7, -7, 1, 0, 0));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 9));
    queue_item(make_item(ACT_TICK, 0, 0, 0, 0, 250));
    queue_item(make_item(ACT_SET, 8'h80, 8'h7F, 8'h81, 2, 8'hFF));
    queue_item(make_item(ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 3, 8'hFF));

    run_phase(127, 1, 1, 1'b1, 290);
    run_phase(1, 64, 7, 1'b1, 290);
    run_phase(60, 3, 25, 1'b0, 290);
    run_phase(127, 64, 65535, 1'b1, 290);
    run_phase(20, 2, 12, 1'b1, 290);
    run_phase(90, 5, 40, 1'b1, 290);
    wait_drained();

    $display("ran %0d items over %0d register settings: %0d ticks, %0d target sets, %0d direct sets",
             n_accepted, n_settings, n_ticks, n_sets, n_directs);
    $display("checked %0d results, %0d watchdog zero ramps, %0d mismatches",
             n_checked, n_fires, n_errors);
    if (n_errors == 0) begin
      $display("three_motor_slew_ramp_timeout_core_tb: PASS");
    end else begin
      $display("three_motor_slew_ramp_timeout_core_tb: FAIL");
    end
    $finish;
  end

endmodule
